>>> hdl/ufrx_pkg.sv
// Shared types and constants for the frame receiver with XOR check.
`timescale 1ns / 1ps
package ufrx_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_END    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_END   = 3'd7;

  // Depth of the queue between parser and classifier (power of two)
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TAIL     = 2'd2,
    ST_LENGTH   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_NORMAL   = 3'd0,
    CLS_TIMING   = 3'd1,
    CLS_UPDATE   = 3'd2,
    CLS_REQUEST  = 3'd3,
    CLS_UNCLASSED = 3'd4
  } class_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] cmd;
    logic [15:0] len;
  } frame_rec_t;

  typedef struct packed {
    logic [15:0] normal_end;
    logic [15:0] timing_start;
    logic [15:0] timing_end;
    logic [15:0] update_start;
    logic [15:0] update_end;
    logic [15:0] request_start;
    logic [15:0] request_end;
  } class_cfg_t;

endpackage

>>> hdl/ufrx_front.sv
// Byte parser: header hunt, field capture, running XOR and frame-end checks.
`timescale 1ns / 1ps
module ufrx_front #(
  parameter int MIN_FRAME_LEN = 10,
  parameter int MAX_FRAME_LEN = 256,
  parameter int HEAD_FIRST    = 170,
  parameter int HEAD_SECOND   = 85
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          tail_byte,
  output logic                push,
  output ufrx_pkg::frame_rec_t push_rec
);

  localparam int PW = $clog2(MAX_FRAME_LEN);
  localparam logic [7:0] HF = 8'(HEAD_FIRST);
  localparam logic [7:0] HS = 8'(HEAD_SECOND);

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'b001,
    PH_HUNT2 = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  phase_t        phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] last_pos, last_pos_next;
  logic [PW-1:0] chk_pos, chk_pos_next;
  logic [7:0]    xor_acc, xor_acc_next;
  logic [7:0]    chk, chk_next;
  logic [15:0]   cmd, cmd_next;
  logic [15:0]   len, len_next;
  logic [16:0]   total;
  logic          past_header;

  assign total       = 17'(MIN_FRAME_LEN) + {1'b0, len[15:8], rx_byte};
  assign past_header = (pos >= PW'(8));

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    last_pos_next = last_pos;
    chk_pos_next  = chk_pos;
    xor_acc_next  = xor_acc;
    chk_next      = chk;
    cmd_next      = cmd;
    len_next      = len;
    push          = 1'b0;
    push_rec.status = ufrx_pkg::ST_GOOD;
    push_rec.cmd    = cmd;
    push_rec.len    = len;
    if (take) begin
      case (phase)
        PH_HUNT2: begin
          if (rx_byte == HS) begin
            phase_next   = PH_BODY;
            xor_acc_next = HF ^ rx_byte;
            pos_next     = PW'(2);
          end else if (rx_byte != HF) begin
            phase_next = PH_HUNT1;
          end
        end
        PH_BODY: begin
          if (past_header && pos == last_pos) begin
            // last byte is the tail; a checksum fault wins over a tail fault
            push       = 1'b1;
            phase_next = PH_HUNT1;
            if (xor_acc != chk) begin
              push_rec.status = ufrx_pkg::ST_CHECKSUM;
            end else if (rx_byte != tail_byte) begin
              push_rec.status = ufrx_pkg::ST_TAIL;
            end
          end else if (past_header && pos == chk_pos) begin
            chk_next = rx_byte;
            pos_next = pos + PW'(1);
          end else begin
            xor_acc_next = xor_acc ^ rx_byte;
            pos_next     = pos + PW'(1);
            case (pos)
              PW'(4): cmd_next = {rx_byte, cmd[7:0]};
              PW'(5): cmd_next = {cmd[15:8], rx_byte};
              PW'(6): len_next = {rx_byte, len[7:0]};
              PW'(7): begin
                len_next      = {len[15:8], rx_byte};
                last_pos_next = PW'(total - 17'd1);
                chk_pos_next  = PW'(total - 17'd2);
                // report an oversized frame at once and drop back to the hunt
                if (total > 17'(MAX_FRAME_LEN)) begin
                  push            = 1'b1;
                  push_rec.status = ufrx_pkg::ST_LENGTH;
                  push_rec.len    = {len[15:8], rx_byte};
                  phase_next      = PH_HUNT1;
                end
              end
              default: ;
            endcase
          end
        end
        default: begin
          phase_next = (rx_byte == HF) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    last_pos <= last_pos_next;
    chk_pos  <= chk_pos_next;
    xor_acc  <= xor_acc_next;
    chk      <= chk_next;
    cmd      <= cmd_next;
    len      <= len_next;
  end

endmodule

>>> hdl/ufrx_queue.sv
// Short queue of frame records between parser and classifier.
`timescale 1ns / 1ps
module ufrx_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ufrx_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output ufrx_pkg::frame_rec_t head_rec
);

  localparam int QW = $clog2(ufrx_pkg::QDEPTH);

  ufrx_pkg::frame_rec_t slots [ufrx_pkg::QDEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [QW:0]   count;

  assign full       = (count == (QW+1)'(ufrx_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QW+1)'(1);
        2'b01:   count <= count - (QW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/ufrx_back.sv
// Command classifier and output register.
`timescale 1ns / 1ps
module ufrx_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ufrx_pkg::class_cfg_t cfg,
  input  logic                 head_valid,
  input  ufrx_pkg::frame_rec_t head_rec,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           frame_status,
  output logic [15:0]          command_code,
  output logic [15:0]          payload_length,
  output logic [2:0]           message_class
);

  function automatic ufrx_pkg::class_t classify(input logic [15:0] c,
                                                input ufrx_pkg::class_cfg_t r);
    ufrx_pkg::class_t k;
    if (c <= r.normal_end) begin
      k = ufrx_pkg::CLS_NORMAL;
    end else if (c >= r.timing_start && c <= r.timing_end) begin
      k = ufrx_pkg::CLS_TIMING;
    end else if (c >= r.update_start && c <= r.update_end) begin
      k = ufrx_pkg::CLS_UPDATE;
    end else if (c >= r.request_start && c <= r.request_end) begin
      k = ufrx_pkg::CLS_REQUEST;
    end else begin
      k = ufrx_pkg::CLS_UNCLASSED;
    end
    return k;
  endfunction

  // advance when the output register is empty or being taken
  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_status   <= head_rec.status;
      command_code   <= head_rec.cmd;
      payload_length <= head_rec.len;
      message_class  <= classify(head_rec.cmd, cfg);
    end
  end

endmodule

>>> hdl/uart_frame_receiver_xor_check_top.sv
// Top level: configuration registers, parser, record queue and classifier.
// Takes one byte per cycle; a frame's result passes through the record queue
// and then the classifier's output register before it is valid.
// Input stalls only while the two-entry record queue is full.
// Synchronous reset clears the parser, queue, output valid and all
// configuration registers to zero.
`timescale 1ns / 1ps
module uart_frame_receiver_xor_check_top #(
  parameter int MIN_FRAME_LEN = 10,
  parameter int MAX_FRAME_LEN = 256,
  parameter int HEAD_FIRST    = 170,
  parameter int HEAD_SECOND   = 85
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ufrx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufrx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     frame_status,
  output logic [15:0]                    command_code,
  output logic [15:0]                    payload_length,
  output logic [2:0]                     message_class
);

  logic                 [7:0] tail_byte;
  ufrx_pkg::class_cfg_t cls_cfg;
  logic                 take;
  logic                 push;
  ufrx_pkg::frame_rec_t push_rec;
  logic                 q_full;
  logic                 pop;
  logic                 head_valid;
  ufrx_pkg::frame_rec_t head_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_byte <= '0;
      cls_cfg   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ufrx_pkg::REG_TAIL_BYTE:     tail_byte             <= cfg_data[7:0];
        ufrx_pkg::REG_NORMAL_END:    cls_cfg.normal_end    <= cfg_data;
        ufrx_pkg::REG_TIMING_START:  cls_cfg.timing_start  <= cfg_data;
        ufrx_pkg::REG_TIMING_END:    cls_cfg.timing_end    <= cfg_data;
        ufrx_pkg::REG_UPDATE_START:  cls_cfg.update_start  <= cfg_data;
        ufrx_pkg::REG_UPDATE_END:    cls_cfg.update_end    <= cfg_data;
        ufrx_pkg::REG_REQUEST_START: cls_cfg.request_start <= cfg_data;
        ufrx_pkg::REG_REQUEST_END:   cls_cfg.request_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold input while the queue has no room for a record
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  ufrx_front #(
    .MIN_FRAME_LEN (MIN_FRAME_LEN),
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .HEAD_FIRST    (HEAD_FIRST),
    .HEAD_SECOND   (HEAD_SECOND)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .tail_byte (tail_byte),
    .push      (push),
    .push_rec  (push_rec)
  );

  ufrx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  ufrx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cls_cfg),
    .head_valid     (head_valid),
    .head_rec       (head_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_status   (frame_status),
    .command_code   (command_code),
    .payload_length (payload_length),
    .message_class  (message_class)
  );

endmodule

>>> bench/uart_frame_receiver_xor_check_top_test.sv
// Self-checking bench for the frame receiver with XOR check: directed and random framing.
`timescale 1ns / 1ps
module uart_frame_receiver_xor_check_top_test;

  localparam int          PERIOD        = 10;
  localparam int          MIN_FRAME_LEN = 10;
  localparam int          MAX_FRAME_LEN = 256;
  localparam logic [7:0]  HEAD_FIRST    = 8'hAA;
  localparam logic [7:0]  HEAD_SECOND   = 8'h55;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          CFG_EVERY     = 300;
  localparam int          LIMIT_NS      = 5_000_000;

  typedef enum logic [2:0] {
    HUNT_HEAD   = 3'b001,
    HUNT_SECOND = 3'b010,
    IN_BODY     = 3'b100
  } parse_phase_t;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct {
    ufrx_pkg::status_t status;
    logic [15:0]       cmd;
    logic [15:0]       len;
    ufrx_pkg::class_t  cls;
  } frame_report_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ufrx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ufrx_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      rx_byte = 8'h00;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      frame_status;
  logic [15:0]                     command_code;
  logic [15:0]                     payload_length;
  logic [2:0]                      message_class;

  uart_frame_receiver_xor_check_top #(
    .MIN_FRAME_LEN(MIN_FRAME_LEN),
    .MAX_FRAME_LEN(MAX_FRAME_LEN),
    .HEAD_FIRST(HEAD_FIRST),
    .HEAD_SECOND(HEAD_SECOND)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_status(frame_status),
    .command_code(command_code),
    .payload_length(payload_length),
    .message_class(message_class)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Parser shadow state and register copy
  logic [15:0]   cfg_shadow [8];
  parse_phase_t  phase = HUNT_HEAD;
  int unsigned   byte_pos = 0;
  logic [7:0]    run_xor = 8'h00;
  logic [15:0]   held_cmd = 16'h0000;
  logic [15:0]   held_len = 16'h0000;
  logic [7:0]    held_sum = 8'h00;

  frame_report_t frame_reports [$];

  int unsigned errors = 0;
  int unsigned bytes_accepted = 0;
  int unsigned frames_checked = 0;
  int unsigned status_count [4];
  int unsigned class_count [5];
  int unsigned burst_left = 0;
  int unsigned long_holds = 0;

  // Receiver stall pattern state
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_FREE;

  initial begin
    foreach (cfg_shadow[i]) cfg_shadow[i] = 16'h0000;
    foreach (status_count[i]) status_count[i] = 0;
    foreach (class_count[i]) class_count[i] = 0;
  end

  function automatic ufrx_pkg::class_t classify_command(input logic [15:0] cmd);
    if (cmd <= cfg_shadow[ufrx_pkg::REG_NORMAL_END]) return ufrx_pkg::CLS_NORMAL;
    if (cmd >= cfg_shadow[ufrx_pkg::REG_TIMING_START] &&
        cmd <= cfg_shadow[ufrx_pkg::REG_TIMING_END])
      return ufrx_pkg::CLS_TIMING;
    if (cmd >= cfg_shadow[ufrx_pkg::REG_UPDATE_START] &&
        cmd <= cfg_shadow[ufrx_pkg::REG_UPDATE_END])
      return ufrx_pkg::CLS_UPDATE;
    if (cmd >= cfg_shadow[ufrx_pkg::REG_REQUEST_START] &&
        cmd <= cfg_shadow[ufrx_pkg::REG_REQUEST_END])
      return ufrx_pkg::CLS_REQUEST;
    return ufrx_pkg::CLS_UNCLASSED;
  endfunction

  function automatic void close_frame(input ufrx_pkg::status_t st);
    frame_report_t rep;
    rep.status = st;
    rep.cmd    = held_cmd;
    rep.len    = held_len;
    rep.cls    = classify_command(held_cmd);
    frame_reports.push_back(rep);
    phase    = HUNT_HEAD;
    byte_pos = 0;
    run_xor  = 8'h00;
  endfunction

  // Advance the shadow parser by one accepted byte
  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned frame_len;
    frame_len = MIN_FRAME_LEN + held_len;
    if (phase == HUNT_SECOND) begin
      if (b == HEAD_SECOND) begin
        phase    = IN_BODY;
        run_xor  = HEAD_FIRST ^ b;
        byte_pos = 2;
      end else if (b != HEAD_FIRST) begin
        phase = HUNT_HEAD;
      end
    end else if (phase != IN_BODY) begin
      phase    = (b == HEAD_FIRST) ? HUNT_SECOND : HUNT_HEAD;
      byte_pos = 0;
    end else if (byte_pos >= 8 && byte_pos == frame_len - 1) begin
      if (run_xor != held_sum) close_frame(ufrx_pkg::ST_CHECKSUM);
      else if (b != cfg_shadow[ufrx_pkg::REG_TAIL_BYTE][7:0]) close_frame(ufrx_pkg::ST_TAIL);
      else close_frame(ufrx_pkg::ST_GOOD);
    end else if (byte_pos >= 8 && byte_pos == frame_len - 2) begin
      held_sum = b;
      byte_pos++;
    end else begin
      run_xor = run_xor ^ b;
      case (byte_pos)
        4: held_cmd[15:8] = b;
        5: held_cmd[7:0]  = b;
        6: held_len[15:8] = b;
        7: held_len[7:0]  = b;
        default: ;
      endcase
      if (byte_pos == 7 && MIN_FRAME_LEN + held_len > MAX_FRAME_LEN)
        close_frame(ufrx_pkg::ST_LENGTH);
      else byte_pos++;
    end
  endfunction

  // Offer one item; bursts of random length with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    absorb_byte(b);
    bytes_accepted++;
  endtask

  task automatic wait_until_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ufrx_pkg::CFG_IDX_W-1:0] reg_code(input int unsigned i);
    case (i)
      0: return ufrx_pkg::REG_TAIL_BYTE;
      1: return ufrx_pkg::REG_NORMAL_END;
      2: return ufrx_pkg::REG_TIMING_START;
      3: return ufrx_pkg::REG_TIMING_END;
      4: return ufrx_pkg::REG_UPDATE_START;
      5: return ufrx_pkg::REG_UPDATE_END;
      6: return ufrx_pkg::REG_REQUEST_START;
      default: return ufrx_pkg::REG_REQUEST_END;
    endcase
  endfunction

  // Write all eight registers once the block has drained
  task automatic load_config(input logic [15:0] tail, norm_end, tim_lo, tim_hi,
                             upd_lo, upd_hi, req_lo, req_hi);
    logic [15:0] vals [8];
    vals[0] = tail;   vals[1] = norm_end;
    vals[2] = tim_lo; vals[3] = tim_hi;
    vals[4] = upd_lo; vals[5] = upd_hi;
    vals[6] = req_lo; vals[7] = req_hi;
    wait_until_idle();
    for (int unsigned i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_code(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      // only the low byte of the tail register is kept
      cfg_shadow[reg_code(i)] = (reg_code(i) == ufrx_pkg::REG_TAIL_BYTE)
                                ? {8'h00, vals[i][7:0]} : vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                            input bit bad_sum, input bit bad_tail, input bit extra_head);
    logic [7:0] bytes [$];
    logic [7:0] sum;
    if (extra_head) bytes.push_back(HEAD_FIRST);
    bytes.push_back(HEAD_FIRST);
    bytes.push_back(HEAD_SECOND);
    sum = HEAD_FIRST ^ HEAD_SECOND;
    for (int i = 2; i < 8; i++) begin
      logic [7:0] b;
      case (i)
        4: b = cmd[15:8];
        5: b = cmd[7:0];
        6: b = len[15:8];
        7: b = len[7:0];
        default: b = 8'($urandom);
      endcase
      sum = sum ^ b;
      bytes.push_back(b);
    end
    if (MIN_FRAME_LEN + len <= MAX_FRAME_LEN) begin
      for (int i = 0; i < len; i++) begin
        logic [7:0] b;
        b   = 8'($urandom);
        sum = sum ^ b;
        bytes.push_back(b);
      end
      bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
      bytes.push_back(bad_tail
                      ? cfg_shadow[ufrx_pkg::REG_TAIL_BYTE][7:0] ^ 8'($urandom_range(1, 255))
                      : cfg_shadow[ufrx_pkg::REG_TAIL_BYTE][7:0]);
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic test_reset_defaults();
    send_frame(16'h0000, 16'd0, 0, 0, 0);
    send_frame(16'h0001, 16'd0, 0, 0, 0);
    send_frame(16'hFFFF, 16'd1, 0, 1, 0);
  endtask

  task automatic test_classes();
    load_config(16'hFF7E, 16'h00FF, 16'h0100, 16'h01FF, 16'h0200, 16'h02FF,
                16'h0300, 16'h03FF);
    send_frame(16'h00FF, 16'd0, 0, 0, 0);
    send_frame(16'h0100, 16'd0, 0, 0, 0);
    send_frame(16'h02FF, 16'd0, 0, 0, 0);
    send_frame(16'h0300, 16'd0, 0, 0, 0);
    send_frame(16'h0400, 16'd0, 0, 0, 0);
  endtask

  task automatic test_frame_errors();
    send_frame(16'h0155, 16'd2, 1, 0, 0);
    send_frame(16'h0255, 16'd1, 0, 1, 0);
    // checksum and tail both wrong: checksum wins
    send_frame(16'h0355, 16'd0, 1, 1, 0);
    // repeated first header byte keeps the hunt open
    send_frame(16'h0011, 16'd3, 0, 0, 1);
    send_frame(16'h0101, 16'd247, 0, 0, 0);
    send_frame(16'hFFFF, 16'hFFFF, 0, 0, 0);
    send_frame(16'h0202, 16'd246, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'd0, 0, 0, 0);
    send_frame(16'h8000, 16'd0, 0, 1, 0);
    // overlapping ranges resolve to the first that holds the command; a reversed one is empty
    load_config(16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF,
                16'hFFFF, 16'h0000);
    send_frame(16'h0000, 16'd0, 0, 0, 0);
    send_frame(16'h0001, 16'd0, 0, 0, 0);
    send_frame(16'h8000, 16'd0, 0, 0, 0);
    load_config(16'h0042, 16'h0000, 16'hFFFF, 16'h0000, 16'h1000, 16'h0FFF,
                16'h0000, 16'hFFFF);
    send_frame(16'h1000, 16'd0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    wait_until_idle();
    hold_request = 1'b1;
    repeat (12) send_frame(16'($urandom), 16'd0, 0, 0, 0);
  endtask

  task automatic random_config();
    logic [15:0] lo [3];
    logic [15:0] hi [3];
    for (int i = 0; i < 3; i++) begin
      lo[i] = 16'($urandom);
      hi[i] = ($urandom_range(0, 7) == 0) ? lo[i] - 16'd1
                                          : lo[i] + 16'($urandom_range(0, 16'h3000));
      if (hi[i] < lo[i] && $urandom_range(0, 1)) hi[i] = 16'hFFFF;
    end
    load_config(16'($urandom), ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 16'h3FFF)),
                lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  function automatic logic [15:0] random_command();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return cfg_shadow[reg_code($urandom_range(1, 7))] + 16'($urandom_range(0, 2)) - 16'd1;
  endfunction

  function automatic logic [15:0] random_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 16'($urandom_range(0, 8));
    if (pick < 85) return 16'($urandom_range(9, 40));
    if (pick < 92) return 16'($urandom_range(41, 199));
    return 16'($urandom_range(200, 246));
  endfunction

  task automatic test_random();
    int unsigned start_bytes;
    int unsigned next_cfg;
    int unsigned pick;
    int unsigned flaw;
    start_bytes = bytes_accepted;
    next_cfg    = bytes_accepted + CFG_EVERY;
    while (bytes_accepted - start_bytes < RANDOM_ITEMS) begin
      if (bytes_accepted >= next_cfg) begin
        random_config();
        next_cfg = bytes_accepted + CFG_EVERY;
      end
      pick = $urandom_range(0, 99);
      flaw = $urandom_range(0, 9);
      if (pick < 78) begin
        send_frame(random_command(), random_length(), flaw == 7 || flaw == 9,
                   flaw == 8 || flaw == 9, $urandom_range(0, 9) == 0);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (pick < 90) begin
        send_byte(HEAD_FIRST);
      end else if (pick < 94) begin
        // header and a few body bytes, then drop the frame
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
      end else begin
        send_frame(random_command(),
                   ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(247, 16'hFFFE)),
                   0, 0, 0);
      end
    end
  endtask

  // Receiver stall pattern; a requested long hold overrides it
  always @(posedge clk) begin : rx_stall_pattern
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      long_holds++;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    frame_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_reports.size() == 0) begin
        $error("result with nothing pending: frame_status %0d command_code %h", frame_status,
               command_code);
        errors++;
      end else begin
        want = frame_reports.pop_front();
        if (frame_status !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, frame_status);
          errors++;
        end
        if (command_code !== want.cmd) begin
          $error("command_code: expected %h, got %h", want.cmd, command_code);
          errors++;
        end
        if (payload_length !== want.len) begin
          $error("payload_length: expected %0d, got %0d", want.len, payload_length);
          errors++;
        end
        if (message_class !== want.cls) begin
          $error("message_class: expected %0d, got %0d", want.cls, message_class);
          errors++;
        end
        frames_checked++;
        status_count[want.status]++;
        class_count[want.cls]++;
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results still pending", frame_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_classes();
    test_frame_errors();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_until_idle();
    $display("%0d bytes, %0d frames checked; good %0d, checksum %0d, tail %0d, length %0d",
             bytes_accepted, frames_checked, status_count[ufrx_pkg::ST_GOOD],
             status_count[ufrx_pkg::ST_CHECKSUM], status_count[ufrx_pkg::ST_TAIL],
             status_count[ufrx_pkg::ST_LENGTH]);
    $display("classes normal %0d, timing %0d, update %0d, request %0d, unclassed %0d; long holds %0d",
             class_count[ufrx_pkg::CLS_NORMAL], class_count[ufrx_pkg::CLS_TIMING],
             class_count[ufrx_pkg::CLS_UPDATE], class_count[ufrx_pkg::CLS_REQUEST],
             class_count[ufrx_pkg::CLS_UNCLASSED], long_holds);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
